// File: sv/shdd_pkg.sv
package shdd_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD_PERM = 2'd0,
      FUNC_VERTEX    = 2'd1,
      FUNC_CLEAR     = 2'd2,
      FUNC_NONE      = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_NEW       = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   localparam int MAX_VERTICES = 256;
   localparam int HASH_ROWS    = 4093;

   localparam logic [30:0] CNT_MAX  = 31'h7FFF_FFFF;
   localparam logic [8:0]  SIZE_MAX = 9'd511;

   // work handed from the front end to the back end: one finished set or a clear
   typedef struct packed {
      logic [31:0] first_key;
      logic [31:0] second_key;
      logic [8:0]  set_size;
      logic        clear;
   } job_type;

   // 3^n mod 2^32 for every vertex, entry n at bits [32*n +: 32]
   function automatic logic [32*MAX_VERTICES-1:0] pow3_table();
      logic [32*MAX_VERTICES-1:0] t;
      logic [31:0]                r;
      t = '0;
      r = 32'd1;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         t[32*i +: 32] = r;
         r = r * 32'd3;
      end
      return t;
   endfunction

   localparam logic [32*MAX_VERTICES-1:0] POW3_TABLE = pow3_table();

endpackage

// File: sv/shdd_front.sv
module shdd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [7:0]              req_vertex,
   input  logic [7:0]              req_perm_value,
   input  logic                    req_last,
   output logic                    job_valid,
   input  logic                    job_ready,
   output shdd_pkg::job_type       job_data,
   output logic [31:0]             pair_add,
   output logic                    pair_add_valid
);
   import shdd_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   typedef enum logic [1:0] {
      FR_IDLE, FR_UPDATE, FR_PUSH, FR_CLEAR
   } fr_state_type;

   logic [31:0] freq_mem [MAX_VERTICES];
   logic [7:0]  perm_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] freq_valid_ff;

   fr_state_type state_ff, state_in;
   logic [31:0] first_ff, second_ff;
   logic [8:0]  size_ff;
   logic        last_ff;
   logic [VW-1:0] v_ff;
   logic [31:0] freq_rd_ff;
   logic [7:0]  perm_rd_ff;

   logic [VW-1:0] v_idx;
   logic          take;
   logic [31:0]   freq_cur;
   logic [VW-1:0] p_idx;
   logic [31:0]   pow_v, pow_p;

   assign v_idx = req_vertex[VW-1:0];
   assign req_ready = (state_ff == FR_IDLE);
   assign take = req_valid && req_ready;
   assign freq_cur = freq_valid_ff[v_ff] ? freq_rd_ff : 32'd0;
   assign p_idx = perm_rd_ff[VW-1:0];
   assign pow_v = POW3_TABLE[{v_ff, 5'b0} +: 32];
   assign pow_p = POW3_TABLE[{p_idx, 5'b0} +: 32];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (take) begin
               if (req_func == FUNC_VERTEX) state_in = FR_UPDATE;
               else if (req_func == FUNC_CLEAR) state_in = FR_CLEAR;
            end
         end
         FR_UPDATE: if (last_ff) state_in = FR_PUSH; else state_in = FR_IDLE;
         FR_PUSH:   if (job_ready) state_in = FR_IDLE;
         FR_CLEAR:  if (job_ready) state_in = FR_IDLE;
         default:   state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      job_valid = (state_ff == FR_PUSH) || (state_ff == FR_CLEAR);
      job_data.first_key  = first_ff;
      job_data.second_key = second_ff;
      job_data.set_size   = size_ff;
      job_data.clear      = (state_ff == FR_CLEAR);
      pair_add       = freq_cur;
      pair_add_valid = (state_ff == FR_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         freq_rd_ff <= freq_mem[v_idx];
         perm_rd_ff <= perm_mem[v_idx];
         v_ff       <= v_idx;
         last_ff    <= req_last;
         if (req_func == FUNC_LOAD_PERM) perm_mem[v_idx] <= req_perm_value;
      end
      if (state_ff == FR_UPDATE)
         freq_mem[v_ff] <= (freq_cur == 32'hFFFF_FFFF) ? freq_cur : freq_cur + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FR_IDLE;
         freq_valid_ff <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         size_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (take && req_func == FUNC_CLEAR) freq_valid_ff <= '0;
         if (state_ff == FR_UPDATE) begin
            freq_valid_ff[v_ff] <= 1'b1;
            first_ff  <= first_ff + pow_v;
            second_ff <= second_ff + pow_p;
            if (size_ff != SIZE_MAX) size_ff <= size_ff + 9'd1;
         end
         if (state_ff == FR_PUSH && job_ready) begin
            first_ff  <= '0;
            second_ff <= '0;
            size_ff   <= '0;
         end
      end
   end
endmodule

// File: sv/shdd_back.sv
module shdd_back #(
   parameter int SLOTS_PER_ROW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  shdd_pkg::job_type  job_data,
   input  logic [31:0]        pair_add,
   input  logic               pair_add_valid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_row_index,
   output logic [31:0]        rsp_second_key,
   output logic [30:0]        rsp_walk_count,
   output logic [30:0]        rsp_vertex_total,
   output logic [30:0]        rsp_pair_total,
   output logic [30:0]        rsp_conflict_count
);
   import shdd_pkg::*;

   localparam int NSLOTS = HASH_ROWS * SLOTS_PER_ROW;
   localparam int AW     = $clog2(NSLOTS);
   localparam int RW     = $clog2(HASH_ROWS);
   localparam int SW     = $clog2(SLOTS_PER_ROW + 1);
   // floor(2^32 / HASH_ROWS): the quotient estimate is exact or one short
   localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(HASH_ROWS);
   localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

   typedef enum logic [2:0] {
      BK_WIPE, BK_IDLE, BK_MUL, BK_SUB, BK_FIX, BK_READ, BK_CHECK, BK_OUT
   } bk_state_type;

   logic [31:0] slot_mem [NSLOTS];

   bk_state_type state_ff, state_in;
   logic [AW-1:0] wipe_ff;
   logic [31:0]   q_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   mag_ff;
   logic [31:0]   key_ff;
   logic [AW-1:0] base_ff;
   logic [SW-1:0] slot_ff;
   logic [31:0]   rd_ff;
   logic [1:0]    status_ff;
   logic [30:0]   walks_ff, verts_ff, pairs_ff, confl_ff;
   logic [30:0]   pairs_out_ff;
   logic [RW-1:0] row_ff;

   logic [63:0]   recip_prod;
   logic [31:0]   q_times_rows;
   logic [31:0]   rem_fix;
   logic          hit, empty;
   logic [AW-1:0] addr;
   logic          accept;

   function automatic logic [30:0] sat(input logic [30:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {2'b0, a} + {1'b0, b};
      return (s > {2'b0, CNT_MAX}) ? CNT_MAX : s[30:0];
   endfunction

   assign recip_prod   = 64'(mag_ff) * 64'(RECIP);
   assign q_times_rows = q_ff * 32'(HASH_ROWS);
   assign rem_fix = (rem_ff >= 32'(HASH_ROWS)) ? rem_ff - 32'(HASH_ROWS) : rem_ff;
   assign addr   = base_ff + AW'(slot_ff);
   assign hit    = (rd_ff == key_ff);
   assign empty  = rd_ff[31];
   assign job_ready = (state_ff == BK_IDLE);
   assign accept = job_valid && job_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_WIPE:  if (wipe_ff == AW'(NSLOTS - 1)) state_in = BK_IDLE;
         BK_IDLE:  if (accept && !job_data.clear) state_in = BK_MUL;
         BK_MUL:   state_in = BK_SUB;
         BK_SUB:   state_in = BK_FIX;
         BK_FIX:   state_in = BK_READ;
         BK_READ:  state_in = BK_CHECK;
         BK_CHECK: begin
            if (hit || empty || slot_ff == SW'(SLOTS_PER_ROW - 1)) state_in = BK_OUT;
            else state_in = BK_READ;
         end
         BK_OUT:   if (rsp_ready) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid          = (state_ff == BK_OUT);
      rsp_status         = status_ff;
      rsp_row_index      = 12'(row_ff);
      rsp_second_key     = key_ff;
      rsp_walk_count     = walks_ff;
      rsp_vertex_total   = verts_ff;
      rsp_pair_total     = pairs_out_ff;
      rsp_conflict_count = confl_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_WIPE) slot_mem[wipe_ff] <= 32'hFFFF_FFFF;
      else if (state_ff == BK_CHECK && !hit && empty) slot_mem[addr] <= key_ff;
      if (state_ff == BK_READ) rd_ff <= slot_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_WIPE;
         wipe_ff   <= '0;
         walks_ff  <= '0;
         verts_ff  <= '0;
         pairs_ff  <= '0;
         confl_ff  <= '0;
         status_ff <= STATUS_FULL;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_WIPE) wipe_ff <= wipe_ff + AW'(1);
         if (pair_add_valid) pairs_ff <= sat(pairs_ff, pair_add);
         if (accept) begin
            if (job_data.clear) begin
               walks_ff <= '0;
               verts_ff <= '0;
               pairs_ff <= '0;
            end else begin
               walks_ff <= sat(walks_ff, 32'd1);
               verts_ff <= sat(verts_ff, 32'(job_data.set_size));
               // later vertices keep adding to pairs_ff while this set is scanned
               pairs_out_ff <= pairs_ff;
               key_ff   <= job_data.second_key;
               mag_ff   <= job_data.first_key[31] ? 32'd0 - job_data.first_key
                                                  : job_data.first_key;
               slot_ff  <= '0;
               status_ff <= STATUS_FULL;
            end
         end
         if (state_ff == BK_MUL) q_ff <= recip_prod[63:32];
         if (state_ff == BK_SUB) rem_ff <= mag_ff - q_times_rows;
         if (state_ff == BK_FIX) begin
            row_ff  <= RW'(rem_fix);
            base_ff <= AW'(rem_fix * SLOTS_PER_ROW);
         end
         if (state_ff == BK_CHECK) begin
            if (hit) begin
               status_ff <= STATUS_DUPLICATE;
               confl_ff  <= sat(confl_ff, 32'd1);
            end else if (empty) status_ff <= STATUS_NEW;
            else slot_ff <= slot_ff + SW'(1);
         end
      end
   end
endmodule

// File: sv/set_hash_duplicate_detector.sv
// Set hash duplicate detector.
// req_*: one item per transfer. func load stores a permutation entry, func
// vertex adds one set member, func clear zeroes frequencies and the walk,
// vertex and pair totals. A vertex with req_last set closes the set.
// rsp_*: one result per closed set: status, hash row, second key, counters.
// Each vertex passes FR_IDLE and FR_UPDATE for the frequency memory
// read-modify-write, and a new vertex is taken only after the last one's
// update; a closing vertex then waits in FR_PUSH for the one-entry handoff
// to the back end. The back end works out the row remainder in BK_MUL,
// BK_SUB and BK_FIX, then scans up to SLOTS_PER_ROW slots, each in BK_READ
// and BK_CHECK.
// After reset the back end sweeps all HASH_ROWS*SLOTS_PER_ROW slots
// (40930 by default) before it takes a set; vertices are still
// accepted until a closed set waits on it.
// A stalled rsp_ready holds the result and backs up the front end once the
// next closed set is ready.
module set_hash_duplicate_detector #(
   parameter int SLOTS_PER_ROW = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_vertex,
   input  logic [7:0]  req_perm_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_row_index,
   output logic [31:0] rsp_second_key,
   output logic [30:0] rsp_walk_count,
   output logic [30:0] rsp_vertex_total,
   output logic [30:0] rsp_pair_total,
   output logic [30:0] rsp_conflict_count
);
   import shdd_pkg::*;

   logic        job_valid, job_ready;
   job_type     job_data;
   logic [31:0] pair_add;
   logic        pair_add_valid;

   shdd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_vertex,
      .req_perm_value, .req_last, .job_valid, .job_ready, .job_data,
      .pair_add, .pair_add_valid
   );

   shdd_back #(.SLOTS_PER_ROW(SLOTS_PER_ROW)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_data, .pair_add,
      .pair_add_valid, .rsp_valid, .rsp_ready, .rsp_status, .rsp_row_index,
      .rsp_second_key, .rsp_walk_count, .rsp_vertex_total, .rsp_pair_total,
      .rsp_conflict_count
   );
endmodule

// File: sv/shdd_checker.sv
module shdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [30:0] rsp_walk_count,
   input logic [30:0] rsp_conflict_count
);
   import shdd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_FULL)
      else $error("bad status");

   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_walk_count != 31'd0)
      else $error("result with zero walk count");

   a_dup_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DUPLICATE |-> rsp_conflict_count != 31'd0)
      else $error("duplicate without conflict count");
endmodule

bind set_hash_duplicate_detector shdd_checker u_shdd_checker (
   .clock, .reset, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_walk_count, .rsp_conflict_count
);
